// File: rtl/pee_pkg.sv
// Shared types and constants for the postfix expression evaluator.
// Holds the sequencer state, the status codes, the character codes and the
// divider request and response structs. It depends on nothing.
`default_nettype none

package pee_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_MUL   = 8'h2A;
  localparam logic [7:0] CHAR_DIV   = 8'h2F;

  localparam int unsigned DivSteps = 8;
  localparam int unsigned DivCntW  = 4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_DIVZ  = 2'd2,
    ST_OVER  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_B,
    S_POP_A,
    S_EXEC,
    S_DIV,
    S_PUSH,
    S_FINAL,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic              start;
    logic signed [7:0] dividend;
    logic signed [7:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic signed [7:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/pee_divider.sv
// Iterative 8-bit signed divider, one quotient bit per cycle, truncating
// toward zero. Depends on pee_pkg for the request and response structs.
`default_nettype none

module pee_divider
  import pee_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic [7:0]         rem_q, rem_d;
  logic [7:0]         quo_q, quo_d;
  logic [7:0]         dvs_q, dvs_d;
  logic               neg_q, neg_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;

  logic [8:0] trial;
  logic       fits;

  assign trial = {rem_q, quo_q[7]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (busy_q) begin
      // The remainder stays below the divisor, so eight bits hold it.
      rem_d = fits ? 8'(trial - {1'b0, dvs_q}) : trial[7:0];
      quo_d = {quo_q[6:0], fits};
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      rem_d  = 8'd0;
      quo_d  = req_i.dividend[7] ? 8'(-req_i.dividend) : req_i.dividend;
      dvs_d  = req_i.divisor[7] ? 8'(-req_i.divisor) : req_i.divisor;
      neg_d  = req_i.dividend[7] ^ req_i.divisor[7];
      cnt_d  = DivCntW'(DivSteps);
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? 8'(-quo_q) : quo_q;

endmodule

`default_nettype wire

// File: rtl/postfix_expression_evaluator_core.sv
// Top level of the postfix expression evaluator: operand stack memory,
// item sequencer and output register. Depends on pee_pkg and pee_divider.
//
// Usage: one expression character enters per request on the input channel
// (symbol_i, last_i, handshake in_valid_i / in_stall_o). The characters
// + - * / pop two operands and push the wrapped 8-bit result; any other
// character pushes its value minus the code of '0'. On a request marked
// last, the final value is popped and one result request (result_value_o,
// status_o) goes out on the output channel (out_valid_o / out_stall_i),
// carrying the first error seen in the expression. The stack is then empty.
//
// Steps per request: a digit is pushed; + - and * read the two operands
// from the registered stack memory, compute and write the result back;
// / also waits while the divider produces one quotient bit per cycle, and
// a division by zero skips the divider.
// A request marked last adds the final pop and the hand-off into the
// output register.
// A result waits in the output register while the receiver stalls, and
// the block keeps taking requests; only a second result that finds the
// register still full holds the sequencer until it drains.
// Reset empties the stack, clears the error and marks the output register empty.
`default_nettype none

module postfix_expression_evaluator_core
  import pee_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [7:0]        symbol_i,
  input  wire logic              last_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic signed [7:0]      result_value_o,
  output logic [1:0]             status_o
);

  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);

  // Operand stack, one write and one registered read per cycle.
  logic [7:0]       stack_mem [STACK_DEPTH];
  logic [AddrW-1:0] rd_addr;
  logic [AddrW-1:0] wr_addr;
  logic             wr_en;
  logic [7:0]       rd_data_q;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  status_e           err_q, err_d;
  logic [7:0]        sym_q, sym_d;
  logic              last_q, last_d;
  logic              b_ok_q, b_ok_d;
  logic              a_ok_q, a_ok_d;
  logic              fin_ok_q, fin_ok_d;
  logic signed [7:0] b_q, b_d;
  logic signed [7:0] res_q, res_d;

  logic              out_valid_q, out_valid_d;
  logic signed [7:0] out_value_q, out_value_d;
  status_e           out_status_q, out_status_d;

  logic [CntW-1:0]    cnt_m1;
  logic               stack_empty;
  logic               stack_full;
  logic signed [7:0]  op_a;
  logic signed [15:0] product;
  logic               is_op;
  logic               out_free;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign cnt_m1      = cnt_q - CntW'(1);
  assign stack_empty = (cnt_q == '0);
  assign stack_full  = (cnt_q >= CntW'(STACK_DEPTH));
  assign rd_addr     = cnt_m1[AddrW-1:0];
  assign wr_addr     = cnt_q[AddrW-1:0];
  assign op_a        = a_ok_q ? $signed(rd_data_q) : 8'sd0;
  assign product     = op_a * b_q;
  assign is_op       = (sym_q == CHAR_PLUS) || (sym_q == CHAR_MINUS) ||
                       (sym_q == CHAR_MUL) || (sym_q == CHAR_DIV);
  assign out_free    = !out_valid_q || !out_stall_i;

  pee_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    err_d        = err_q;
    sym_d        = sym_q;
    last_d       = last_q;
    b_ok_d       = b_ok_q;
    a_ok_d       = a_ok_q;
    fin_ok_d     = fin_ok_q;
    b_d          = b_q;
    res_d        = res_q;
    wr_en        = 1'b0;
    in_stall_o   = 1'b1;
    out_valid_d  = out_valid_q && out_stall_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    div_req.start    = 1'b0;
    div_req.dividend = op_a;
    div_req.divisor  = b_q;

    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          sym_d   = symbol_i;
          last_d  = last_i;
          res_d   = $signed(8'(symbol_i - CHAR_ZERO));
          // Operators go to the two pops, every other character pushes.
          if ((symbol_i == CHAR_PLUS) || (symbol_i == CHAR_MINUS) ||
              (symbol_i == CHAR_MUL) || (symbol_i == CHAR_DIV)) begin
            state_d = S_POP_B;
          end else begin
            state_d = S_PUSH;
          end
        end
      end
      S_POP_B: begin
        // Read the top entry; an empty stack yields zero and flags underflow.
        b_ok_d = !stack_empty;
        if (stack_empty) begin
          if (err_q == ST_OK) err_d = ST_UNDER;
        end else begin
          cnt_d = cnt_m1;
        end
        state_d = S_POP_A;
      end
      S_POP_A: begin
        b_d    = b_ok_q ? $signed(rd_data_q) : 8'sd0;
        a_ok_d = !stack_empty;
        if (stack_empty) begin
          if (err_q == ST_OK) err_d = ST_UNDER;
        end else begin
          cnt_d = cnt_m1;
        end
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_PUSH;
        priority if (sym_q == CHAR_PLUS) begin
          res_d = op_a + b_q;
        end else if (sym_q == CHAR_MINUS) begin
          res_d = op_a - b_q;
        end else if (sym_q == CHAR_MUL) begin
          res_d = product[7:0];
        end else if (b_q == 8'sd0) begin
          res_d = 8'sd0;
          if (err_q == ST_OK) err_d = ST_DIVZ;
        end else begin
          div_req.start = 1'b1;
          state_d       = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_d   = div_rsp.quotient;
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (stack_full) begin
          if (err_q == ST_OK) err_d = ST_OVER;
        end else begin
          wr_en = 1'b1;
          cnt_d = cnt_q + CntW'(1);
        end
        state_d = last_q ? S_FINAL : S_IDLE;
      end
      S_FINAL: begin
        // The entry written in the previous cycle is already in the memory.
        fin_ok_d = !stack_empty;
        if (stack_empty && (err_q == ST_OK)) err_d = ST_UNDER;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = fin_ok_q ? $signed(rd_data_q) : 8'sd0;
          out_status_d = err_q;
          cnt_d        = '0;
          err_d        = ST_OK;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q        <= sym_d;
    last_q       <= last_d;
    b_ok_q       <= b_ok_d;
    a_ok_q       <= a_ok_d;
    fin_ok_q     <= fin_ok_d;
    b_q          <= b_d;
    res_q        <= res_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= res_q;
    end
    rd_data_q <= stack_mem[rd_addr];
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign status_o       = out_status_q;

  // The fill count never exceeds the stack depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // A result held by a stalled receiver keeps the sequencer in the emit state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_valid_q && out_stall_i) |=> state_q == S_EMIT)
    else $error("emit overwrote a pending result");

  // After a result is handed off the stack and the error are cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free) |=> (cnt_q == '0 && err_q == ST_OK && out_valid_q))
    else $error("stack not cleared after result");

  // The divider reports completion only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV)
    else $error("divider finished outside the divide state");

  // While the sequencer waits on a division the divider is working or done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> (div_rsp.busy || div_rsp.done))
    else $error("divide state with an idle divider");

  // Only operator characters reach the compute state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |-> is_op)
    else $error("non-operator reached compute state");

endmodule

`default_nettype wire

// File: bench/postfix_expression_evaluator_core_test.sv
// Self-checking testbench for postfix_expression_evaluator_core.
// A queue-fed driver and a clocked monitor check every result request against
// a stack-based predictor; it depends on pee_pkg and the core RTL.
`default_nettype none

module postfix_expression_evaluator_core_test
  import pee_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STACK_SIZE = 128;
  // Cycles without any accepted request before the run is declared hung. The
  // longest legal quiet stretch is the HOLD_CYCLES receiver hold plus one
  // division, so this leaves several times the margin.
  localparam int unsigned HANG_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned HOLD_AFTER = 120;
  localparam int unsigned QUIET_TAIL = 60;
  localparam int unsigned RANDOM_CHARS = 520;

  // Bytes that push the extreme operands: byte minus '0' gives 127 and -128.
  localparam logic [7:0] SYM_POS_MAX = 8'hAF;
  localparam logic [7:0] SYM_NEG_MAX = 8'hB0;

  typedef struct {
    logic [7:0] symbol;
    logic       last;
    bit         drain;  // hold this request back until all results are in
  } char_req_t;

  typedef struct {
    logic signed [7:0] value;
    status_e           status;
  } eval_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        symbol = '0;
  logic              last = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [7:0] result_value;
  logic [1:0]        status;

  char_req_t    pending[$];
  eval_result_t expected_results[$];

  // Predictor state: a private copy of the operand stack and the sticky error.
  logic [7:0]  model_stack [STACK_SIZE];
  int unsigned model_depth = 0;
  status_e     model_error = ST_OK;

  int unsigned chars_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned exprs_predicted = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};
  int unsigned failures = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_started = 1'b0;

  postfix_expression_evaluator_core #(
    .STACK_DEPTH(STACK_SIZE)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .symbol_i      (symbol),
    .last_i        (last),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .result_value_o(result_value),
    .status_o      (status)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic bit is_operator(logic [7:0] s);
    return s == CHAR_PLUS || s == CHAR_MINUS || s == CHAR_MUL || s == CHAR_DIV;
  endfunction

  // Random idling is allowed except in one of every three 64-request windows
  // and in the tail of the run, so both busy and quiet stretches occur.
  function automatic bit idling_allowed();
    return pending.size() > QUIET_TAIL && ((chars_accepted >> 6) % 3 != 2);
  endfunction

  // Only the first error of an expression is kept.
  function automatic void note_error(status_e code);
    if (model_error == ST_OK) model_error = code;
  endfunction

  function automatic void push_operand(logic [7:0] v);
    if (model_depth >= STACK_SIZE) begin
      note_error(ST_OVER);
    end else begin
      model_stack[model_depth] = v;
      model_depth++;
    end
  endfunction

  // Popping an empty stack yields zero and flags underflow; it never reads an
  // entry that was not written.
  function automatic logic signed [7:0] pop_operand();
    if (model_depth == 0) begin
      note_error(ST_UNDER);
      return '0;
    end
    model_depth--;
    return model_stack[model_depth];
  endfunction

  // Applies one accepted character to the model stack. A character marked
  // last also pops the final value and queues the expected result request.
  function automatic void evaluate_char(logic [7:0] s, logic is_last);
    int           lhs;
    int           rhs;
    int           res;
    eval_result_t outcome;
    if (is_operator(s)) begin
      rhs = pop_operand();
      lhs = pop_operand();
      case (s)
        CHAR_PLUS:  res = lhs + rhs;
        CHAR_MINUS: res = lhs - rhs;
        CHAR_MUL:   res = lhs * rhs;
        default: begin
          if (rhs == 0) begin
            note_error(ST_DIVZ);
            res = 0;
          end else begin
            // Integer division truncates toward zero; -128 / -1 wraps back.
            res = lhs / rhs;
          end
        end
      endcase
      push_operand(res[7:0]);
    end else begin
      push_operand(s - CHAR_ZERO);
    end
    if (is_last) begin
      outcome.value = pop_operand();
      outcome.status = model_error;
      expected_results.push_back(outcome);
      exprs_predicted++;
      model_depth = 0;
      model_error = ST_OK;
    end
  endfunction

  task automatic add_char(logic [7:0] s, logic is_last, bit drain = 1'b0);
    char_req_t req;
    req.symbol = s;
    req.last = is_last;
    req.drain = drain;
    pending.push_back(req);
  endtask

  function automatic logic [7:0] random_operand();
    logic [7:0] s;
    if ($urandom_range(0, 1) == 0) begin
      s = CHAR_ZERO + 8'($urandom_range(0, 9));
    end else begin
      s = 8'($urandom_range(0, 255));
      if (is_operator(s)) s = CHAR_ZERO;
    end
    return s;
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(0, 3))
      0:       return CHAR_PLUS;
      1:       return CHAR_MINUS;
      2:       return CHAR_MUL;
      default: return CHAR_DIV;
    endcase
  endfunction

  // Queues one random expression and returns how many characters it holds.
  // Most are well-formed postfix with random operands; the rest is noise with
  // random bytes and random end marks, which also breaks expressions apart.
  task automatic add_random_expression(output int unsigned count, input bit drain);
    int unsigned operands;
    int unsigned left;
    int unsigned depth;
    int unsigned total;
    count = 0;
    if ($urandom_range(0, 7) == 0) begin
      total = $urandom_range(1, 6);
      repeat (total) begin
        add_char(8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0,
                 drain && count == 0);
        count++;
      end
    end else begin
      operands = $urandom_range(1, 7);
      total = 2 * operands - 1;
      left = operands;
      depth = 0;
      while (left > 0 || depth > 1) begin
        if (left > 0 && (depth < 2 || $urandom_range(0, 1) == 0)) begin
          add_char(random_operand(), count == total - 1, drain && count == 0);
          left--;
          depth++;
        end else begin
          add_char(random_operator(), count == total - 1, drain && count == 0);
          depth--;
        end
        count++;
      end
    end
  endtask

  // Driver: a new request is presented only when the previous one has been
  // taken or none was offered, so a stalled request never changes.
  always @(posedge clk_i) begin
    char_req_t req;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        evaluate_char(symbol, last);
        chars_accepted <= chars_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending.size() == 0 ||
                     (pending[0].drain && expected_results.size() != 0)) begin
          // Nothing to send, or a pause until every result has come back.
          in_valid <= 1'b0;
        end else if (idling_allowed() && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(0, 5);
          in_valid <= 1'b0;
        end else begin
          req = pending.pop_front();
          symbol <= req.symbol;
          last <= req.last;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: checks each accepted result request against the oldest
  // expectation and drives the receiver stall, including one long hold that
  // backs the block up while the driver keeps offering requests.
  always @(posedge clk_i) begin
    eval_result_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result request with no expression pending: value %0d, status %0d",
                 result_value, status);
          failures++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          status_seen[want.status]++;
          if (result_value !== want.value) begin
            $error("result_value: expected %0d, actual %0d", want.value, result_value);
            failures++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            failures++;
          end
        end
      end
      if (!hold_started && chars_accepted >= HOLD_AFTER) begin
        hold_started = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idling_allowed() && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: any accepted request on either channel restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= HANG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int unsigned random_count;
    int unsigned n;
    bit          overflow_done;
    random_count = 0;
    overflow_done = 1'b0;

    // Directed part: single characters at the byte extremes and the largest
    // positive operand.
    add_char("7", 1'b1);
    add_char(8'h00, 1'b1);
    add_char(8'hFF, 1'b1);
    add_char(SYM_POS_MAX, 1'b1);
    // Each operator once, with wrapping multiply and truncating divide.
    add_char("3", 1'b0);
    add_char("4", 1'b0);
    add_char(CHAR_PLUS, 1'b1);
    add_char(SYM_POS_MAX, 1'b0);
    add_char("2", 1'b0);
    add_char(CHAR_MUL, 1'b1);
    add_char("0", 1'b0);
    add_char("7", 1'b0);
    add_char(CHAR_MINUS, 1'b0);
    add_char("2", 1'b0);
    add_char(CHAR_DIV, 1'b1);
    // Division by zero.
    add_char("5", 1'b0);
    add_char("0", 1'b0);
    add_char(CHAR_DIV, 1'b1);
    // The most negative value divided by minus one wraps to itself.
    add_char(SYM_NEG_MAX, 1'b0);
    add_char("0", 1'b0);
    add_char("1", 1'b0);
    add_char(CHAR_MINUS, 1'b0);
    add_char(CHAR_DIV, 1'b1);
    // An operator on an empty stack underflows.
    add_char(CHAR_PLUS, 1'b1);
    // Entries left below the final value are discarded.
    add_char("1", 1'b0);
    add_char("2", 1'b1);

    // Random part. The first random request waits for the directed results.
    add_random_expression(n, 1'b1);
    random_count += n;
    while (random_count < RANDOM_CHARS) begin
      if (!overflow_done && random_count > 250) begin
        // Push past the full stack: the last two pushes are dropped.
        overflow_done = 1'b1;
        for (int unsigned i = 0; i < STACK_SIZE + 2; i++) begin
          add_char(random_operand(), i == STACK_SIZE + 1, i == 0);
        end
        random_count += STACK_SIZE + 2;
      end else begin
        add_random_expression(n, 1'b0);
        random_count += n;
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (30) @(posedge clk_i);

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      failures++;
    end
    $display("Run covered %0d characters and %0d checked expressions.",
             chars_accepted, results_checked);
    $display("Status mix: %0d ok, %0d underflow, %0d divide by zero, %0d overflow.",
             status_seen[ST_OK], status_seen[ST_UNDER], status_seen[ST_DIVZ],
             status_seen[ST_OVER]);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
